// File: design/i2cm_pkg.sv
// shared types and constants of the i2c register access master
package i2cm_pkg;

    // request codes carried by req_type
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam int unsigned BYTE_BITS = 8;
    localparam logic [2:0]  LAST_BIT  = 3'(BYTE_BITS - 1);

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_ST1      = 5'd1,
        PH_ST2      = 5'd2,
        PH_DEV      = 5'd3,
        PH_DEV_ACK  = 5'd4,
        PH_REG      = 5'd5,
        PH_REG_ACK  = 5'd6,
        PH_DATA     = 5'd7,
        PH_DATA_ACK = 5'd8,
        PH_RS0      = 5'd9,
        PH_RS1      = 5'd10,
        PH_RS2      = 5'd11,
        PH_DEVR     = 5'd12,
        PH_DEVR_ACK = 5'd13,
        PH_RECV     = 5'd14,
        PH_NACK     = 5'd15,
        PH_SP0      = 5'd16,
        PH_SP1      = 5'd17,
        PH_SP2      = 5'd18
    } phase_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] dev_addr;
        logic [7:0] reg_addr;
        logic [7:0] wr_data;
        logic       sda_in;
    } req_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rd_data;
        logic       ack_error;
    } res_t;

endpackage

// File: design/i2cm_req_if.sv
// request channel: one bus tick with an optional transaction request
interface i2cm_req_if
    import i2cm_pkg::*;
();
    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: design/i2cm_res_if.sv
// result channel: bus levels and status for one tick
interface i2cm_res_if
    import i2cm_pkg::*;
();
    logic valid;
    logic ready;
    res_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: design/i2cm_seq.sv
// bit and byte sequencer of the i2c master, one tick per step
module i2cm_seq
    import i2cm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  req_t item,
    output res_t result
);

    phase_t     phase_reg, phase_next;
    logic       half_reg, half_next;
    logic [2:0] bit_cnt_reg, bit_cnt_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] dev_reg, dev_next;
    logic [7:0] regad_reg, regad_next;
    logic [7:0] data_reg, data_next;
    logic       is_read_reg, is_read_next;
    logic [7:0] recv_reg, recv_next;
    logic       nack_reg, nack_next;

    // working copies after a possible request latch
    phase_t     cur_phase;
    logic       cur_half;
    logic [2:0] cur_bit_cnt;
    logic       byte_end;
    logic       scl, sda, busy, done;

    // bit timing and state advance
    always_comb
    begin
        phase_next   = phase_reg;
        half_next    = half_reg;
        bit_cnt_next = bit_cnt_reg;
        shift_next   = shift_reg;
        dev_next     = dev_reg;
        regad_next   = regad_reg;
        data_next    = data_reg;
        is_read_next = is_read_reg;
        recv_next    = recv_reg;
        nack_next    = nack_reg;

        if (phase_reg == PH_IDLE &&
            (item.req_type == REQ_WRITE || item.req_type == REQ_READ))
        begin
            dev_next     = item.dev_addr;
            regad_next   = item.reg_addr;
            data_next    = item.wr_data;
            is_read_next = (item.req_type == REQ_READ);
            nack_next    = 1'b0;
            cur_phase    = PH_ST1;
            cur_half     = 1'b0;
            cur_bit_cnt  = '0;
        end
        else
        begin
            cur_phase   = phase_reg;
            cur_half    = half_reg;
            cur_bit_cnt = bit_cnt_reg;
        end
        phase_next   = cur_phase;
        half_next    = cur_half;
        bit_cnt_next = cur_bit_cnt;

        // end of the eighth bit's high half
        byte_end = cur_half && (cur_bit_cnt == LAST_BIT);

        unique case (cur_phase)
            PH_ST1:
            begin
                phase_next = PH_ST2;
            end
            PH_ST2:
            begin
                phase_next   = PH_DEV;
                shift_next   = dev_next;
                half_next    = 1'b0;
                bit_cnt_next = '0;
            end
            PH_DEV, PH_REG, PH_DATA, PH_DEVR:
            begin
                half_next = ~cur_half;
                if (cur_half)
                begin
                    shift_next   = {shift_reg[6:0], 1'b0};
                    bit_cnt_next = byte_end ? 3'd0 : cur_bit_cnt + 3'd1;
                end
                if (byte_end)
                begin
                    unique case (cur_phase)
                        PH_DEV:  phase_next = PH_DEV_ACK;
                        PH_REG:  phase_next = PH_REG_ACK;
                        PH_DATA: phase_next = PH_DATA_ACK;
                        default: phase_next = PH_DEVR_ACK;
                    endcase
                end
            end
            PH_DEV_ACK, PH_REG_ACK, PH_DATA_ACK, PH_DEVR_ACK:
            begin
                half_next = ~cur_half;
                if (cur_half)
                begin
                    if (item.sda_in)
                        nack_next = 1'b1;
                    bit_cnt_next = '0;
                    unique case (cur_phase)
                        PH_DEV_ACK:
                        begin
                            phase_next = PH_REG;
                            shift_next = regad_reg;
                        end
                        PH_REG_ACK:
                        begin
                            if (is_read_reg)
                                phase_next = PH_RS0;
                            else
                            begin
                                phase_next = PH_DATA;
                                shift_next = data_reg;
                            end
                        end
                        PH_DATA_ACK:
                        begin
                            phase_next = PH_SP0;
                        end
                        default:
                        begin
                            phase_next = PH_RECV;
                            shift_next = '0;
                        end
                    endcase
                end
            end
            PH_RS0:
            begin
                phase_next = PH_RS1;
            end
            PH_RS1:
            begin
                phase_next = PH_RS2;
            end
            PH_RS2:
            begin
                phase_next   = PH_DEVR;
                shift_next   = dev_reg + 8'd1;
                half_next    = 1'b0;
                bit_cnt_next = '0;
            end
            PH_RECV:
            begin
                half_next = ~cur_half;
                if (cur_half)
                begin
                    shift_next   = {shift_reg[6:0], item.sda_in};
                    bit_cnt_next = byte_end ? 3'd0 : cur_bit_cnt + 3'd1;
                end
                if (byte_end)
                begin
                    recv_next  = shift_next;
                    phase_next = PH_NACK;
                end
            end
            PH_NACK:
            begin
                half_next = ~cur_half;
                if (cur_half)
                    phase_next = PH_SP0;
            end
            PH_SP0:
            begin
                phase_next = PH_SP1;
            end
            PH_SP1:
            begin
                phase_next = PH_SP2;
            end
            PH_SP2:
            begin
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next   = PH_IDLE;
                half_next    = 1'b0;
                bit_cnt_next = '0;
            end
        endcase
    end

    // bus levels for this tick
    always_comb
    begin
        scl  = 1'b1;
        sda  = 1'b1;
        busy = 1'b1;
        done = 1'b0;
        unique case (cur_phase)
            PH_ST1, PH_RS1:
            begin
            end
            PH_ST2, PH_RS2, PH_SP1:
            begin
                sda = 1'b0;
            end
            PH_DEV, PH_REG, PH_DATA, PH_DEVR:
            begin
                scl = cur_half;
                sda = shift_reg[7];
            end
            PH_DEV_ACK, PH_REG_ACK, PH_DATA_ACK, PH_DEVR_ACK, PH_RECV, PH_NACK:
            begin
                scl = cur_half;
            end
            PH_RS0:
            begin
                scl = 1'b0;
            end
            PH_SP0:
            begin
                scl = 1'b0;
                sda = 1'b0;
            end
            PH_SP2:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    assign result.scl_out   = scl;
    assign result.sda_out   = sda;
    assign result.busy_res  = busy;
    assign result.done_res  = done;
    assign result.rd_data   = recv_next;
    assign result.ack_error = nack_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            half_reg    <= 1'b0;
            bit_cnt_reg <= '0;
            shift_reg   <= '0;
            dev_reg     <= '0;
            regad_reg   <= '0;
            data_reg    <= '0;
            is_read_reg <= 1'b0;
            recv_reg    <= '0;
            nack_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            half_reg    <= half_next;
            bit_cnt_reg <= bit_cnt_next;
            shift_reg   <= shift_next;
            dev_reg     <= dev_next;
            regad_reg   <= regad_next;
            data_reg    <= data_next;
            is_read_reg <= is_read_next;
            recv_reg    <= recv_next;
            nack_reg    <= nack_next;
        end
    end

endmodule

// File: design/i2c_register_access_master.sv
// top level of the i2c register access master: input stage, sequencer, result stage
// path: an accepted tick waits in the input stage, then a step registers its result into the result stage
// throughput: one tick per cycle unless the result side stalls, set by the single-step sequencer update
// backpressure: a stalled result stage holds one tick in the input stage, then blocks req_ch
// reset: asynchronous active-low rst_n returns the sequencer to idle with all
// latched bytes, received byte and ack error flag cleared, both stages empty
module i2c_register_access_master
    import i2cm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    i2cm_req_if.sink   req_ch,
    i2cm_res_if.source res_ch
);

    // input stage
    logic in_valid_reg;
    req_t in_data_reg;

    // result stage
    logic out_valid_reg;
    res_t out_data_reg;

    // sequencer step and its result for the held tick
    logic advance;
    res_t seq_result;

    // the held tick moves on when the result stage is empty or being emptied
    assign advance      = in_valid_reg && (!out_valid_reg || res_ch.ready);
    assign req_ch.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req_ch.ready)
            in_valid_reg <= req_ch.valid;
    end

    // payload register needs no reset
    always_ff @(posedge clk)
    begin
        if (req_ch.ready && req_ch.valid)
            in_data_reg <= req_ch.payload;
    end

    // sequencer updates its state only on a step
    i2cm_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_data_reg),
        .result (seq_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (res_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= seq_result;
    end

    assign res_ch.valid   = out_valid_reg;
    assign res_ch.payload = out_data_reg;

    // a step always leaves a result waiting
    a_step_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("step did not fill the result stage");

    // a held tick is never dropped while the result side stalls
    a_held_tick_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("held tick lost");

    // an idle tick leaves both lines released
    a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.busy_res |->
            out_data_reg.scl_out && out_data_reg.sda_out)
        else $error("bus driven while idle");

    // done marks the stop condition: both lines high during a busy tick
    a_done_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.done_res |->
            out_data_reg.busy_res && out_data_reg.scl_out && out_data_reg.sda_out)
        else $error("done without stop condition");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the i2c register access master, driven one bus tick per transfer
module tb_top;
    import i2cm_pkg::*;

    // bus ticks a whole transaction occupies, request tick included:
    // write = start(2) + three bytes with ack(3 x 18) + stop(3)
    // read  = start(2) + two bytes with ack(36) + repeated start(3) + read address(18)
    //         + eight received bits(16) + nack(2) + stop(3)
    localparam int WRITE_TICKS  = 59;
    localparam int READ_TICKS   = 80;
    localparam int RANDOM_TICKS = 490;
    // no transfer on either channel for this long means the block is stuck
    localparam int STALL_LIMIT  = 200;
    localparam int MAX_SHOWN    = 10;
    // slack left after the last expected result has arrived
    localparam int DRAIN_CYCLES = 8;
    // unused request code, the block must treat it as a plain tick
    localparam logic [1:0] REQ_SPARE = 2'd3;

    typedef enum {SDA_LOW, SDA_HIGH, SDA_RAND} sda_drive_t;

    // one request tick plus, for real requests, the plain ticks that carry the
    // transaction to its stop
    typedef struct {
        logic [1:0] code;
        logic [7:0] dev;
        logic [7:0] regb;
        logic [7:0] data;
        sda_drive_t sda;
        bit         noisy;  // stray requests sprinkled over the busy ticks
        bit         chk;    // request tick has a hand-written expectation
        res_t       want;
    } bus_op_t;

    logic clk;
    logic rst_n;

    i2cm_req_if req_ch();
    i2cm_res_if res_ch();

    i2c_register_access_master dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req_ch (req_ch),
        .res_ch (res_ch)
    );

    always #4 clk = ~clk;

    // hand-written expectation riding along with the tick currently offered
    bit   tick_chk;
    res_t tick_want;

    bit quiet = 1'b0;

    res_t levels_due[$];
    bus_op_t directed[$];

    int n_sent      = 0;
    int n_checked   = 0;
    int n_errors    = 0;
    int n_writes    = 0;
    int n_reads     = 0;
    int n_ignored   = 0;
    int n_nack_done = 0;
    int stall_cycles = 0;

    // ------------------------------------------------------------------
    // sequencer predictor, its own copy of the master's state
    // ------------------------------------------------------------------
    phase_t     bus_phase = PH_IDLE;
    logic       half_hi   = 1'b0;
    logic [2:0] bit_idx   = '0;
    logic [7:0] out_shift = '0;
    logic [7:0] dev_byte  = '0;
    logic [7:0] reg_byte  = '0;
    logic [7:0] data_byte = '0;
    logic       read_op   = 1'b0;
    logic [7:0] rx_byte   = '0;
    logic       nack_flag = 1'b0;

    function automatic void load_byte(phase_t next, logic [7:0] value);
        bus_phase = next;
        out_shift = value;
        half_hi   = 1'b0;
        bit_idx   = '0;
    endfunction

    // steps the low/high halves of a bit, true once the eighth bit's high half is over
    function automatic bit bit_slot_done();
        if (!half_hi)
        begin
            half_hi = 1'b1;
            return 1'b0;
        end
        half_hi = 1'b0;
        if (bit_idx >= LAST_BIT)
        begin
            bit_idx = '0;
            return 1'b1;
        end
        bit_idx = bit_idx + 3'd1;
        return 1'b0;
    endfunction

    function automatic res_t predict_bus_tick(req_t t);
        res_t   r;
        phase_t ph;
        r = '0;
        r.scl_out  = 1'b1;
        r.sda_out  = 1'b1;
        r.busy_res = 1'b1;

        if (t.req_type == REQ_WRITE || t.req_type == REQ_READ)
        begin
            if (bus_phase == PH_IDLE)
            begin
                // operands latched, the request tick is already the first start tick
                dev_byte  = t.dev_addr;
                reg_byte  = t.reg_addr;
                data_byte = t.wr_data;
                read_op   = (t.req_type == REQ_READ);
                nack_flag = 1'b0;
                half_hi   = 1'b0;
                bit_idx   = '0;
                bus_phase = PH_ST1;
                if (read_op)
                    n_reads++;
                else
                    n_writes++;
            end
            else
                n_ignored++;
        end

        ph = bus_phase;
        case (ph)
            PH_ST1:
                bus_phase = PH_ST2;
            PH_ST2:
            begin
                r.sda_out = 1'b0;
                load_byte(PH_DEV, dev_byte);
            end
            PH_DEV, PH_REG, PH_DATA, PH_DEVR:
            begin
                r.scl_out = half_hi;
                r.sda_out = out_shift[7];
                if (half_hi)
                    out_shift = {out_shift[6:0], 1'b0};
                if (bit_slot_done())
                begin
                    bus_phase = phase_t'(ph + 5'd1);
                    half_hi   = 1'b0;
                end
            end
            PH_DEV_ACK, PH_REG_ACK, PH_DATA_ACK, PH_DEVR_ACK:
            begin
                r.scl_out = half_hi;
                if (!half_hi)
                    half_hi = 1'b1;
                else
                begin
                    half_hi = 1'b0;
                    if (t.sda_in)
                        nack_flag = 1'b1;
                    case (ph)
                        PH_DEV_ACK:
                            load_byte(PH_REG, reg_byte);
                        PH_REG_ACK:
                            if (read_op)
                                bus_phase = PH_RS0;
                            else
                                load_byte(PH_DATA, data_byte);
                        PH_DATA_ACK:
                            bus_phase = PH_SP0;
                        default:
                            load_byte(PH_RECV, 8'h00);
                    endcase
                end
            end
            PH_RS0:
            begin
                r.scl_out = 1'b0;
                bus_phase = PH_RS1;
            end
            PH_RS1:
                bus_phase = PH_RS2;
            PH_RS2:
            begin
                r.sda_out = 1'b0;
                load_byte(PH_DEVR, dev_byte + 8'd1);
            end
            PH_RECV:
            begin
                r.scl_out = half_hi;
                if (half_hi)
                    out_shift = {out_shift[6:0], t.sda_in};
                if (bit_slot_done())
                begin
                    rx_byte   = out_shift;
                    bus_phase = PH_NACK;
                    half_hi   = 1'b0;
                end
            end
            PH_NACK:
            begin
                r.scl_out = half_hi;
                if (!half_hi)
                    half_hi = 1'b1;
                else
                begin
                    half_hi   = 1'b0;
                    bus_phase = PH_SP0;
                end
            end
            PH_SP0:
            begin
                r.scl_out = 1'b0;
                r.sda_out = 1'b0;
                bus_phase = PH_SP1;
            end
            PH_SP1:
            begin
                r.sda_out = 1'b0;
                bus_phase = PH_SP2;
            end
            PH_SP2:
            begin
                r.done_res = 1'b1;
                bus_phase  = PH_IDLE;
                if (nack_flag)
                    n_nack_done++;
            end
            default:
            begin
                r.busy_res = 1'b0;
                bus_phase  = PH_IDLE;
                half_hi    = 1'b0;
                bit_idx    = '0;
            end
        endcase

        r.rd_data   = rx_byte;
        r.ack_error = nack_flag;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic sda_level(sda_drive_t mode);
        case (mode)
            SDA_LOW:  return 1'b0;
            SDA_HIGH: return 1'b1;
            default:  return 1'($urandom_range(0, 1));
        endcase
    endfunction

    // levels of the first start tick or an idle tick: both lines high, no done
    function automatic res_t bus_high(logic busy, logic [7:0] rd, logic ack);
        res_t r;
        r.scl_out   = 1'b1;
        r.sda_out   = 1'b1;
        r.busy_res  = busy;
        r.done_res  = 1'b0;
        r.rd_data   = rd;
        r.ack_error = ack;
        return r;
    endfunction

    function automatic bus_op_t make_op(logic [1:0] code, logic [7:0] dev, logic [7:0] regb,
                                        logic [7:0] data, sda_drive_t sda, bit noisy,
                                        bit chk, res_t want);
        bus_op_t op;
        op.code  = code;
        op.dev   = dev;
        op.regb  = regb;
        op.data  = data;
        op.sda   = sda;
        op.noisy = noisy;
        op.chk   = chk;
        op.want  = want;
        return op;
    endfunction

    // offers one tick and returns once its transfer has happened
    task automatic send_tick(req_t t, bit chk, res_t want);
        // occasional sender gap before the tick
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= t;
        tick_chk       <= chk;
        tick_want      <= want;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        n_sent++;
    endtask

    // request tick, then plain ticks until the transaction has reached its stop
    task automatic run_bus_op(bus_op_t op);
        req_t t;
        int   fill;
        t.req_type = op.code;
        t.dev_addr = op.dev;
        t.reg_addr = op.regb;
        t.wr_data  = op.data;
        t.sda_in   = sda_level(op.sda);
        send_tick(t, op.chk, op.want);
        if (op.code == REQ_WRITE)
            fill = WRITE_TICKS - 1;
        else if (op.code == REQ_READ)
            fill = READ_TICKS - 1;
        else
            fill = 0;
        repeat (fill)
        begin
            // stray requests while busy must be ignored
            if (op.noisy && $urandom_range(0, 3) == 0)
                t.req_type = 2'($urandom_range(1, 3));
            else
                t.req_type = REQ_TICK;
            t.dev_addr = 8'($urandom);
            t.reg_addr = 8'($urandom);
            t.wr_data  = 8'($urandom);
            t.sda_in   = sda_level(op.sda);
            send_tick(t, 1'b0, '0);
        end
    endtask

    function automatic void log_error(string msg);
        n_errors++;
        if (n_errors <= MAX_SHOWN)
            $display("%s", msg);
    endfunction

    // ------------------------------------------------------------------
    // result side: random stall bursts, none in the quiet tail
    // ------------------------------------------------------------------
    initial
    begin : sink_side
        int stall_left;
        bit rdy;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                rdy = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 7) - 1;
                rdy = 1'b0;
            end
            else
                rdy = 1'b1;
            res_ch.ready <= rdy;
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on each tick transfer, check each result transfer
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        res_t got;
        res_t want;
        if (rst_n)
        begin
            // check first so a result can never meet the tick of the same edge
            if (res_ch.valid && res_ch.ready)
            begin
                got = res_ch.payload;
                if (levels_due.size() == 0)
                    log_error($sformatf("result transfer with nothing expected: %h", got));
                else
                begin
                    want = levels_due.pop_front();
                    n_checked++;
                    if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
                        got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
                        got.rd_data !== want.rd_data || got.ack_error !== want.ack_error)
                        log_error($sformatf(
                            {"result %0d mismatch: want scl=%b sda=%b busy=%b done=%b",
                             " rd=%h ack=%b, got scl=%b sda=%b busy=%b done=%b rd=%h ack=%b"},
                            n_checked, want.scl_out, want.sda_out, want.busy_res,
                            want.done_res, want.rd_data, want.ack_error, got.scl_out,
                            got.sda_out, got.busy_res, got.done_res, got.rd_data,
                            got.ack_error));
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                // predictor always advances, a hand-written value overrides its output
                want = predict_bus_tick(req_ch.payload);
                if (tick_chk)
                    want = tick_want;
                levels_due.push_back(want);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, levels_due.size());
            $display("tb_top: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : main
        bus_op_t op;
        int      start_cnt;
        clk = 1'b0;
        rst_n          <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        tick_chk       <= 1'b0;
        tick_want      <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed table: idle after reset, unused code, operand extremes, all-ack and
        // all-nack lines, address wrap on the read phase, sticky error, stray requests
        directed.push_back(make_op(REQ_TICK, 8'h00, 8'h00, 8'h00, SDA_LOW, 1'b0, 1'b1,
                                   bus_high(1'b0, 8'h00, 1'b0)));
        directed.push_back(make_op(REQ_SPARE, 8'hFF, 8'hFF, 8'hFF, SDA_HIGH, 1'b0, 1'b1,
                                   bus_high(1'b0, 8'h00, 1'b0)));
        directed.push_back(make_op(REQ_WRITE, 8'h00, 8'h00, 8'h00, SDA_LOW, 1'b0, 1'b1,
                                   bus_high(1'b1, 8'h00, 1'b0)));
        directed.push_back(make_op(REQ_TICK, 8'h00, 8'h00, 8'h00, SDA_LOW, 1'b0, 1'b1,
                                   bus_high(1'b0, 8'h00, 1'b0)));
        directed.push_back(make_op(REQ_WRITE, 8'hFF, 8'hFF, 8'hFF, SDA_HIGH, 1'b0, 1'b1,
                                   bus_high(1'b1, 8'h00, 1'b0)));
        // error flag stays up after the stop
        directed.push_back(make_op(REQ_TICK, 8'h00, 8'h00, 8'h00, SDA_HIGH, 1'b0, 1'b1,
                                   bus_high(1'b0, 8'h00, 1'b1)));
        // read address wraps to zero, accepting the request clears the flag
        directed.push_back(make_op(REQ_READ, 8'hFF, 8'h00, 8'h00, SDA_HIGH, 1'b0, 1'b1,
                                   bus_high(1'b1, 8'h00, 1'b0)));
        directed.push_back(make_op(REQ_TICK, 8'h00, 8'h00, 8'h00, SDA_LOW, 1'b0, 1'b1,
                                   bus_high(1'b0, 8'hFF, 1'b1)));
        directed.push_back(make_op(REQ_READ, 8'h00, 8'hFF, 8'hFF, SDA_LOW, 1'b0, 1'b1,
                                   bus_high(1'b1, 8'hFF, 1'b0)));
        directed.push_back(make_op(REQ_TICK, 8'h00, 8'h00, 8'h00, SDA_LOW, 1'b0, 1'b1,
                                   bus_high(1'b0, 8'h00, 1'b0)));
        // from here on the predictor supplies the expectations
        directed.push_back(make_op(REQ_WRITE, 8'h5A, 8'hA5, 8'h3C, SDA_RAND, 1'b1, 1'b0, '0));
        directed.push_back(make_op(REQ_READ, 8'hA5, 8'h5A, 8'hC3, SDA_RAND, 1'b1, 1'b0, '0));
        directed.push_back(make_op(REQ_SPARE, 8'h81, 8'h18, 8'h7E, SDA_RAND, 1'b0, 1'b0, '0));
        directed.push_back(make_op(REQ_READ, 8'h7F, 8'h80, 8'h01, SDA_RAND, 1'b0, 1'b0, '0));
        directed.push_back(make_op(REQ_WRITE, 8'h80, 8'h7F, 8'hFE, SDA_LOW, 1'b1, 1'b0, '0));
        foreach (directed[k])
            run_bus_op(directed[k]);

        // random part: mostly whole transactions with random operands and line levels,
        // the rest short runs of plain or unused-code ticks; the tail runs without idling
        start_cnt = n_sent;
        while (n_sent - start_cnt < RANDOM_TICKS)
        begin
            quiet = (n_sent - start_cnt) > (RANDOM_TICKS * 4) / 5;
            op.dev   = 8'($urandom);
            op.regb  = 8'($urandom);
            op.data  = 8'($urandom);
            op.chk   = 1'b0;
            op.want  = '0;
            op.noisy = ($urandom_range(0, 2) == 0);
            case ($urandom_range(0, 4))
                0:       op.sda = SDA_LOW;
                1:       op.sda = SDA_HIGH;
                default: op.sda = SDA_RAND;
            endcase
            if ($urandom_range(0, 9) < 8)
            begin
                op.code = $urandom_range(0, 1) ? REQ_WRITE : REQ_READ;
                run_bus_op(op);
            end
            else
                repeat ($urandom_range(1, 4))
                begin
                    op.code = $urandom_range(0, 1) ? REQ_TICK : REQ_SPARE;
                    run_bus_op(op);
                end
        end

        req_ch.valid <= 1'b0;
        // watchdog covers a block that never delivers the rest
        while (levels_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (levels_due.size() != 0)
            log_error($sformatf("%0d expected results never arrived", levels_due.size()));

        $display("ran %0d writes and %0d reads, %0d of them ending with a missing ack",
                 n_writes, n_reads, n_nack_done);
        $display("%0d stray requests, %0d ticks sent, %0d results checked, %0d mismatches",
                 n_ignored, n_sent, n_checked, n_errors);
        if (n_errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
